[hdl/clmin_pkg.sv]
// Shared constants, codes and types of the cursor list with minimum scan.
`default_nettype none

package clmin_pkg;

   // node store geometry; nil is encoded as NODES
   localparam int NODES  = 16;
   localparam int IDX_W  = $clog2(NODES);
   localparam int LINK_W = IDX_W + 1;

   // item field widths
   localparam int ID_W    = 16;
   localparam int GRADE_W = 16;
   localparam int REC_W   = ID_W + GRADE_W;

   // request modes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_FIND   = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // write request into the link store
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [LINK_W-1:0] data;
   } clmin_link_wr_type;

endpackage : clmin_pkg

`default_nettype wire

[hdl/clmin_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none

module clmin_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : clmin_ram

`default_nettype wire

[hdl/clmin_link_store.sv]
// Link store: RAM plus per-node valid bits; an unwritten node links to the next one.
`default_nettype none

module clmin_link_store
   import clmin_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire clmin_link_wr_type wr,
   input  wire logic [IDX_W-1:0]  rd_addr,
   output logic      [LINK_W-1:0] rd_link
);

   logic [NODES-1:0]  valid_ff;
   logic [NODES-1:0]  valid_in;
   logic [IDX_W-1:0]  rd_addr_ff;
   logic              rd_valid_ff;
   logic [LINK_W-1:0] ram_q;

   clmin_ram #(
      .WIDTH (LINK_W),
      .DEPTH (NODES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // mark a node once its link has been written
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      rd_addr_ff  <= rd_addr;
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // reset chain: node i links to i+1, the last one to nil
   assign rd_link = rd_valid_ff ? ram_q : (LINK_W'(rd_addr_ff) + LINK_W'(1));

endmodule : clmin_link_store

`default_nettype wire

[hdl/cursor_list_insert_and_min_scan.sv]
// Top level: cursor linked list with free chain, insert and minimum-grade scan.
//
// Items are taken with start while busy is low. Each result appears for one
// cycle on the rsp_ ports, marked by rsp_strobe, and cannot be held off.
// An insert keeps busy high through S_INS_A and S_INS_B (head insert) or
// through S_INS_A, S_INS_B and S_INS_C (insert after a predecessor); a full
// list answers without raising busy. A find over a list of n reachable
// nodes (n at most 16) keeps busy high through the first walk (S_SCAN1), the
// second walk (S_SCAN2) and S_FLUSH: one node is visited per cycle in each
// of the two walks, since the node store has one registered read port and
// the next address is the link just read. A find on an empty list answers
// without raising busy. Results of a find come out in list order, the
// final one with rsp_last set.
`default_nettype none

module cursor_list_insert_and_min_scan
   import clmin_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic                     req_mode,
   input  wire logic [ID_W-1:0]          req_rec_id,
   input  wire logic signed [GRADE_W-1:0] req_grade,
   input  wire logic [IDX_W-1:0]         req_pred_index,
   input  wire logic                     req_pred_none,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status,
   output logic [IDX_W-1:0]              rsp_node_slot,
   output logic [ID_W-1:0]               rsp_found_id,
   output logic signed [GRADE_W-1:0]     rsp_min_grade,
   output logic                          rsp_last
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_INS_A = 3'd1;
   localparam logic [2:0] S_INS_B = 3'd2;
   localparam logic [2:0] S_INS_C = 3'd3;
   localparam logic [2:0] S_SCAN1 = 3'd4;
   localparam logic [2:0] S_SCAN2 = 3'd5;
   localparam logic [2:0] S_FLUSH = 3'd6;

   // control state
   logic [2:0]        state_ff, state_in;
   logic [LINK_W-1:0] list_head_ff, list_head_in;
   logic [LINK_W-1:0] free_head_ff, free_head_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   // working registers
   logic [ID_W-1:0]           rec_id_ff, rec_id_in;
   logic signed [GRADE_W-1:0] grade_ff, grade_in;
   logic [IDX_W-1:0]          pred_ff, pred_in;
   logic                      at_head_ff, at_head_in;
   logic [IDX_W-1:0]          tgt_ff, tgt_in;
   logic [IDX_W-1:0]          cur_ff, cur_in;
   logic [LINK_W-1:0]         steps_ff, steps_in;
   logic signed [GRADE_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]          pend_slot_ff, pend_slot_in;
   logic [ID_W-1:0]           pend_id_ff, pend_id_in;

   // result registers
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]          rsp_slot_ff, rsp_slot_in;
   logic [ID_W-1:0]           rsp_id_ff, rsp_id_in;
   logic signed [GRADE_W-1:0] rsp_grade_ff, rsp_grade_in;
   logic                      rsp_last_ff, rsp_last_in;

   // memory ports
   logic [IDX_W-1:0]          rd_addr;
   logic [LINK_W-1:0]         link_rd;
   clmin_link_wr_type         link_wr;
   logic                      rec_wr_en;
   logic [REC_W-1:0]          rec_rd;
   logic [ID_W-1:0]           rd_id;
   logic signed [GRADE_W-1:0] rd_grade;
   logic                      link_nil;
   logic                      list_nil;
   logic                      free_nil;
   logic                      last_step;

   // record store: id and grade of each node
   clmin_ram #(
      .WIDTH (REC_W),
      .DEPTH (NODES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (tgt_ff),
      .wr_data ({rec_id_ff, grade_ff}),
      .rd_addr (rd_addr),
      .rd_data (rec_rd)
   );

   // link store
   clmin_link_store u_links (
      .clock   (clock),
      .reset   (reset),
      .wr      (link_wr),
      .rd_addr (rd_addr),
      .rd_link (link_rd)
   );

   assign rd_id     = rec_rd[REC_W-1:GRADE_W];
   assign rd_grade  = rec_rd[GRADE_W-1:0];
   assign link_nil  = (link_rd >= LINK_W'(NODES));
   assign list_nil  = (list_head_ff >= LINK_W'(NODES));
   assign free_nil  = (free_head_ff >= LINK_W'(NODES));
   assign last_step = (steps_ff == LINK_W'(NODES - 1));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      list_head_in  = list_head_ff;
      free_head_in  = free_head_ff;
      pend_valid_in = pend_valid_ff;
      rec_id_in     = rec_id_ff;
      grade_in      = grade_ff;
      pred_in       = pred_ff;
      at_head_in    = at_head_ff;
      tgt_in        = tgt_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      best_in       = best_ff;
      pend_slot_in  = pend_slot_ff;
      pend_id_in    = pend_id_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_OK;
      rsp_slot_in   = '0;
      rsp_id_in     = '0;
      rsp_grade_in  = '0;
      rsp_last_in   = 1'b0;
      rd_addr       = cur_ff;
      link_wr       = '0;
      rec_wr_en     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_mode == MODE_INSERT) begin
                  if (free_nil) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_FULL;
                     rsp_last_in   = 1'b1;
                  end else begin
                     // fetch the free chain's successor of the taken node
                     rd_addr    = free_head_ff[IDX_W-1:0];
                     tgt_in     = free_head_ff[IDX_W-1:0];
                     rec_id_in  = req_rec_id;
                     grade_in   = req_grade;
                     pred_in    = req_pred_index;
                     at_head_in = req_pred_none
                                  || (LINK_W'(req_pred_index) >= LINK_W'(NODES));
                     state_in   = S_INS_A;
                  end
               end else begin
                  if (list_nil) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_EMPTY;
                     rsp_last_in   = 1'b1;
                  end else begin
                     rd_addr  = list_head_ff[IDX_W-1:0];
                     cur_in   = list_head_ff[IDX_W-1:0];
                     steps_in = '0;
                     state_in = S_SCAN1;
                  end
               end
            end
         end

         S_INS_A: begin
            // unlink from free chain, store the record, fetch predecessor link
            free_head_in = link_rd;
            rec_wr_en    = 1'b1;
            rd_addr      = pred_ff;
            state_in     = S_INS_B;
         end

         S_INS_B: begin
            link_wr.en   = 1'b1;
            link_wr.addr = tgt_ff;
            if (at_head_ff) begin
               link_wr.data  = list_head_ff;
               list_head_in  = LINK_W'(tgt_ff);
               rsp_strobe_in = 1'b1;
               rsp_slot_in   = tgt_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               link_wr.data = link_rd;
               state_in     = S_INS_C;
            end
         end

         S_INS_C: begin
            // predecessor now points at the new node
            link_wr.en    = 1'b1;
            link_wr.addr  = pred_ff;
            link_wr.data  = LINK_W'(tgt_ff);
            rsp_strobe_in = 1'b1;
            rsp_slot_in   = tgt_ff;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end

         S_SCAN1: begin
            // first walk: running minimum
            if ((steps_ff == '0) || (rd_grade < best_ff)) begin
               best_in = rd_grade;
            end
            if (link_nil || last_step) begin
               rd_addr       = list_head_ff[IDX_W-1:0];
               cur_in        = list_head_ff[IDX_W-1:0];
               steps_in      = '0;
               pend_valid_in = 1'b0;
               state_in      = S_SCAN2;
            end else begin
               rd_addr  = link_rd[IDX_W-1:0];
               cur_in   = link_rd[IDX_W-1:0];
               steps_in = steps_ff + LINK_W'(1);
            end
         end

         S_SCAN2: begin
            // second walk: a match is held until the next one shows it is not final
            if (rd_grade == best_ff) begin
               if (pend_valid_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_slot_in   = pend_slot_ff;
                  rsp_id_in     = pend_id_ff;
                  rsp_grade_in  = best_ff;
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = cur_ff;
               pend_id_in    = rd_id;
            end
            if (link_nil || last_step) begin
               state_in = S_FLUSH;
            end else begin
               rd_addr  = link_rd[IDX_W-1:0];
               cur_in   = link_rd[IDX_W-1:0];
               steps_in = steps_ff + LINK_W'(1);
            end
         end

         S_FLUSH: begin
            rsp_strobe_in = pend_valid_ff;
            rsp_slot_in   = pend_slot_ff;
            rsp_id_in     = pend_id_ff;
            rsp_grade_in  = best_ff;
            rsp_last_in   = 1'b1;
            pend_valid_in = 1'b0;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         list_head_ff  <= LINK_W'(NODES);
         free_head_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         list_head_ff  <= list_head_in;
         free_head_ff  <= free_head_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rec_id_ff     <= rec_id_in;
      grade_ff      <= grade_in;
      pred_ff       <= pred_in;
      at_head_ff    <= at_head_in;
      tgt_ff        <= tgt_in;
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      best_ff       <= best_in;
      pend_slot_ff  <= pend_slot_in;
      pend_id_ff    <= pend_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_grade_ff  <= rsp_grade_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_node_slot = rsp_slot_ff;
   assign rsp_found_id  = rsp_id_ff;
   assign rsp_min_grade = rsp_grade_ff;
   assign rsp_last      = rsp_last_ff;

endmodule : cursor_list_insert_and_min_scan

`default_nettype wire

[bench/cursor_list_insert_and_min_scan_tb.sv]
`timescale 1ns / 1ps
// Testbench for the cursor list block: directed and random items checked against a tracked copy.
module cursor_list_insert_and_min_scan_tb;
   import clmin_pkg::*;

   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NODES);

   // one result item as seen on the rsp_ ports
   typedef struct {
      logic [1:0]                status;
      logic [IDX_W-1:0]          slot;
      logic [ID_W-1:0]           id;
      logic signed [GRADE_W-1:0] grade;
      logic                      last;
   } list_rsp_type;

   typedef logic [IDX_W-1:0] node_q_type[$];

   // Tracks the node store, links and both chain heads, and the results still owed.
   class cursor_list_tracker;
      logic [ID_W-1:0]    ids [NODES];
      logic [GRADE_W-1:0] grades [NODES];
      bit                 written [NODES];
      logic [LINK_W-1:0]  links [NODES];
      logic [LINK_W-1:0]  list_head;
      logic [LINK_W-1:0]  free_head;
      list_rsp_type       awaited [$];
      int                 errors;

      function new();
         list_head = NIL_LINK;
         free_head = '0;
         errors = 0;
         for (int i = 0; i < NODES; i++) begin
            ids[i] = '0;
            grades[i] = '0;
            written[i] = 1'b0;
            links[i] = LINK_W'(i + 1);
         end
      endfunction

      // nodes reached from a link, at most NODES of them
      function node_q_type chain_nodes(logic [LINK_W-1:0] first);
         node_q_type        nodes;
         logic [LINK_W-1:0] cur;
         cur = first;
         for (int s = 0; s < NODES && cur < NIL_LINK; s++) begin
            nodes.push_back(cur[IDX_W-1:0]);
            cur = links[cur[IDX_W-1:0]];
         end
         return nodes;
      endfunction

      // a scan must never touch a node whose record was never stored
      function bit scan_is_safe();
         node_q_type nodes;
         nodes = chain_nodes(list_head);
         foreach (nodes[k]) begin
            if (!written[nodes[k]]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void owe(logic [1:0] status, logic [IDX_W-1:0] slot, logic [ID_W-1:0] id,
                        logic [GRADE_W-1:0] grade, logic last);
         list_rsp_type r;
         r.status = status;
         r.slot = slot;
         r.id = id;
         r.grade = grade;
         r.last = last;
         awaited.push_back(r);
      endfunction

      // update the list for an accepted item and queue the results it causes
      function void take_request(logic mode, logic [ID_W-1:0] rid, logic [GRADE_W-1:0] grd,
                                 logic [IDX_W-1:0] pred, logic pnone);
         logic [IDX_W-1:0]          t;
         logic [LINK_W-1:0]         cur;
         logic signed [GRADE_W-1:0] least;
         int                        hits;
         hits = 0;
         if (mode == MODE_INSERT) begin
            if (free_head >= NIL_LINK) begin
               owe(ST_FULL, '0, '0, '0, 1'b1);
            end else begin
               t = free_head[IDX_W-1:0];
               free_head = links[t];
               ids[t] = rid;
               grades[t] = grd;
               written[t] = 1'b1;
               // no membership check on the predecessor
               if (pnone || int'(pred) >= NODES) begin
                  links[t] = list_head;
                  list_head = LINK_W'(t);
               end else begin
                  links[t] = links[pred];
                  links[pred] = LINK_W'(t);
               end
               owe(ST_OK, t, '0, '0, 1'b1);
            end
         end else if (list_head >= NIL_LINK) begin
            owe(ST_EMPTY, '0, '0, '0, 1'b1);
         end else begin
            // first walk: least signed grade
            cur = list_head;
            least = grades[cur[IDX_W-1:0]];
            for (int s = 0; s < NODES && cur < NIL_LINK; s++) begin
               if ($signed(grades[cur[IDX_W-1:0]]) < least) least = grades[cur[IDX_W-1:0]];
               cur = links[cur[IDX_W-1:0]];
            end
            // second walk: every holder of that grade, in list order
            cur = list_head;
            for (int s = 0; s < NODES && cur < NIL_LINK && hits < NODES; s++) begin
               if (grades[cur[IDX_W-1:0]] == least) begin
                  owe(ST_OK, cur[IDX_W-1:0], ids[cur[IDX_W-1:0]], least, 1'b0);
                  hits++;
               end
               cur = links[cur[IDX_W-1:0]];
            end
            if (hits > 0) awaited[awaited.size() - 1].last = 1'b1;
         end
      endfunction

      // compare one strobed result with the oldest owed one
      function void check_response(logic [1:0] status, logic [IDX_W-1:0] slot,
                                   logic [ID_W-1:0] id, logic [GRADE_W-1:0] grade,
                                   logic last);
         list_rsp_type want;
         if (awaited.size() == 0) begin
            $error("unexpected result: status %0d node_slot %0d found_id %0d",
                   status, slot, id);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (want.status !== status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
         end
         if (want.slot !== slot) begin
            $error("node_slot: expected %0d, got %0d", want.slot, slot);
            errors++;
         end
         if (want.id !== id) begin
            $error("found_id: expected %0d, got %0d", want.id, id);
            errors++;
         end
         if (want.grade !== grade) begin
            $error("min_grade: expected %0d, got %0d", want.grade, $signed(grade));
            errors++;
         end
         if (want.last !== last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_mode = MODE_INSERT;
   logic [ID_W-1:0]           req_rec_id = '0;
   logic signed [GRADE_W-1:0] req_grade = '0;
   logic [IDX_W-1:0]          req_pred_index = '0;
   logic                      req_pred_none = 1'b0;
   logic                      rsp_strobe;
   logic [1:0]                rsp_status;
   logic [IDX_W-1:0]          rsp_node_slot;
   logic [ID_W-1:0]           rsp_found_id;
   logic signed [GRADE_W-1:0] rsp_min_grade;
   logic                      rsp_last;

   cursor_list_tracker tracker;

   cursor_list_insert_and_min_scan i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_rec_id     (req_rec_id),
      .req_grade      (req_grade),
      .req_pred_index (req_pred_index),
      .req_pred_none  (req_pred_none),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_node_slot  (rsp_node_slot),
      .rsp_found_id   (rsp_found_id),
      .rsp_min_grade  (rsp_min_grade),
      .rsp_last       (rsp_last)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         tracker.check_response(rsp_status, rsp_node_slot, rsp_found_id, rsp_min_grade,
                                rsp_last);
      end
   end

   // present one item after a gap and hold it until the block takes it
   task automatic send_item(input int gap, input logic mode, input logic [ID_W-1:0] rid,
                            input logic [GRADE_W-1:0] grd, input logic [IDX_W-1:0] pred,
                            input logic pnone);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_rec_id <= rid;
      req_grade <= grd;
      req_pred_index <= pred;
      req_pred_none <= pnone;
      do @(posedge clock); while (busy !== 1'b0);
      tracker.take_request(mode, rid, grd, pred, pnone);
   endtask

   // grades mostly from a small pool so that minimums repeat
   function automatic logic [GRADE_W-1:0] pick_grade();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFF00;
         3: return 16'hFF80;
         4: return 16'h0000;
         5: return 16'h0100;
         default: return GRADE_W'($urandom);
      endcase
   endfunction

   // random item: the list grows slowly; most other inserts reuse free nodes
   task automatic random_item(input int gap);
      node_q_type        listed;
      node_q_type        spare;
      logic              mode;
      logic [ID_W-1:0]   rid;
      logic [GRADE_W-1:0] grd;
      logic [IDX_W-1:0]  pred;
      logic              pnone;
      int                pick;
      listed = tracker.chain_nodes(tracker.list_head);
      spare = tracker.chain_nodes(tracker.free_head);
      rid = ID_W'($urandom);
      grd = pick_grade();
      pred = IDX_W'($urandom);
      pnone = 1'($urandom);
      mode = ($urandom_range(0, 99) < 45) ? MODE_FIND : MODE_INSERT;
      if (mode == MODE_FIND && !tracker.scan_is_safe()) mode = MODE_INSERT;
      if (mode == MODE_INSERT && tracker.free_head < NIL_LINK) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            pnone = 1'b1;
         end else if (pick < 8 && listed.size() > 0) begin
            pnone = 1'b0;
            pred = listed[$urandom_range(0, listed.size() - 1)];
         end else if (pick < 10) begin
            // predecessor is the node being taken: it ends up linked to itself
            pnone = 1'b0;
            pred = tracker.free_head[IDX_W-1:0];
         end else if (pick < 94 && spare.size() > 1) begin
            // predecessor in the free chain: new node goes back among the free ones
            pnone = 1'b0;
            pred = spare[$urandom_range(1, spare.size() - 1)];
         end
      end
      send_item(gap, mode, rid, grd, pred, pnone);
   endtask

   // stimulus
   initial begin
      bit burst;
      tracker = new();
      burst = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty find, extremes, head and middle inserts, odd predecessors
      send_item(0, MODE_FIND, 16'h0000, 16'h0000, 4'h0, 1'b0);
      send_item(3, MODE_INSERT, 16'hFFFF, 16'h7FFF, 4'hF, 1'b1);
      send_item(0, MODE_INSERT, 16'h0000, 16'h0000, 4'h0, 1'b0);
      send_item(1, MODE_INSERT, 16'h5A5A, 16'h8000, 4'h0, 1'b1);
      send_item(0, MODE_FIND, 16'hFFFF, 16'hFFFF, 4'hF, 1'b1);
      send_item(2, MODE_INSERT, 16'hA5A5, 16'h8000, 4'h1, 1'b0);
      send_item(0, MODE_FIND, 16'h0000, 16'h0000, 4'h0, 1'b0);
      send_item(5, MODE_INSERT, 16'h1111, 16'h8000, 4'h9, 1'b0);
      send_item(0, MODE_INSERT, 16'h2222, 16'hFFFF, 4'h5, 1'b0);
      send_item(0, MODE_FIND, 16'h0000, 16'h0000, 4'h0, 1'b0);
      send_item(19, MODE_INSERT, 16'h8001, 16'hFFFF, 4'h3, 1'b0);
      send_item(0, MODE_INSERT, 16'h7FFE, 16'h0001, 4'hA, 1'b1);
      send_item(4, MODE_FIND, 16'h0000, 16'h0000, 4'h0, 1'b0);

      // random part, with stretches of back-to-back items
      for (int n = 0; n < 310; n++) begin
         if (n % 16 == 0) burst = ($urandom_range(0, 3) == 0);
         random_item(burst ? 0 : $urandom_range(0, 19));
      end
      start <= 1'b0;

      // drain, then allow the longest scan to show any stray result
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("cursor_list_insert_and_min_scan: match");
      end else begin
         $display("cursor_list_insert_and_min_scan: mismatch");
      end
      $finish;
   end

   // run limit
   initial begin
      #4ms;
      $display("cursor_list_insert_and_min_scan: mismatch");
      $finish;
   end

endmodule
